[design/bfa_pkg.sv]
// Shared constants and codes for the bitmap frame allocator.
package bfa_pkg;

   localparam int MAX_FRAMES_DEF    = 32768;
   localparam int FRAME_BYTES_DEF   = 4096;
   localparam int BITS_PER_WORD_DEF = 8;

   localparam int ADDR_W = 27;
   localparam int CNT_W  = 16;
   localparam int ACT_W  = 2;
   localparam int STAT_W = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [CNT_W-1:0] TOTAL_RST    = 16'd32768;
   localparam logic [CNT_W-1:0] RESERVED_RST = 16'd0;
   localparam logic [CNT_W-1:0] CNT_SAT      = 16'hFFFF;

   localparam logic [ACT_W-1:0] ACT_INIT  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_OOM      = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOTALLOC = 2'd2;
   localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED = 1'd1;

endpackage

[design/bfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/bitmap_frame_allocator.sv]
// Top level of the first-fit bitmap frame allocator.
//
// First-fit physical frame allocator. One used bit per frame is kept in a
// RAM of words (BITS_PER_WORD rounded up to a power of two bits per word),
// together with a free-frame counter. An item carries an action: init
// rewrites the whole bitmap, marking the leading reserved frames used; alloc
// returns the byte address of the lowest free frame below the configured
// total; free clears the bit of the frame holding req_byte_addr. Every item
// gives exactly one result (status, alloc_addr, free_count). Timing: the
// block takes one item at a time and stalls the request side while it works.
// Init sweeps every RAM word, one word per cycle. Alloc scans the bitmap one
// RAM word per cycle from word 0 and stops at the first word holding a free
// frame. An alloc with a zero count and unknown actions go straight to the
// result; free reads the word of its frame, then tests and clears its bit.
// After reset a clearing pass runs before the first item is taken;
// configuration writes are taken at any time (csr_ready is always high) but
// must only be issued while idle. The result sits in an output register, so a
// finished result may wait on rsp_stall while the block returns to idle and
// takes the next item.
module bitmap_frame_allocator
   import bfa_pkg::*;
#(
   parameter int MAX_FRAMES    = MAX_FRAMES_DEF,
   parameter int FRAME_BYTES   = FRAME_BYTES_DEF,
   parameter int BITS_PER_WORD = BITS_PER_WORD_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ACT_W-1:0]     req_action,
   input  logic [ADDR_W-1:0]    req_byte_addr,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STAT_W-1:0]    rsp_status,
   output logic [ADDR_W-1:0]    rsp_alloc_addr,
   output logic [CNT_W-1:0]     rsp_free_count,
   // register write port
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata
);

   // Bitmap geometry: words are a power of two wide so frame -> word is a shift.
   localparam int LOG_WB     = $clog2(BITS_PER_WORD);
   localparam int WB         = 1 << LOG_WB;
   localparam int WORD_COUNT = (MAX_FRAMES + WB - 1) / WB;
   localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int OFF_W      = $clog2(FRAME_BYTES);
   localparam int FIDX_W     = ADDR_W - OFF_W;
   localparam int FULL_W     = WADDR_W + LOG_WB + OFF_W + ADDR_W;
   localparam logic [WADDR_W-1:0] WORD_LAST = WADDR_W'(WORD_COUNT - 1);

   // Sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;  // bitmap sweep (reset and init)
   localparam logic [2:0] S_SCAN  = 3'd2;  // first-fit search
   localparam logic [2:0] S_FRD   = 3'd3;  // free: read word
   localparam logic [2:0] S_FCHK  = 3'd4;  // free: test and clear bit
   localparam logic [2:0] S_RESP  = 3'd5;  // hand result to output register

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    total_ff, total_in;
   logic [CNT_W-1:0]    reserved_ff, reserved_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [WADDR_W-1:0]  sweep_ff, sweep_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic                init_rsp_ff, init_rsp_in;
   logic [WADDR_W-1:0]  iss_ff, iss_in;
   logic                iss_done_ff, iss_done_in;
   logic                chk_vld_ff, chk_vld_in;
   logic [WADDR_W-1:0]  chk_word_ff, chk_word_in;
   logic [WADDR_W-1:0]  last_ff, last_in;
   logic [FIDX_W-1:0]   frame_ff, frame_in;
   logic [STAT_W-1:0]   res_status_ff, res_status_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [CNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;

   // RAM port signals
   logic                ram_wr_en;
   logic [WADDR_W-1:0]  ram_wr_addr;
   logic [WB-1:0]       ram_wr_data;
   logic [WADDR_W-1:0]  ram_rd_addr;
   logic [WB-1:0]       ram_rd_data;

   // Combinational helpers
   logic [CNT_W-1:0]    eff_tot;
   logic [CNT_W-1:0]    resv_clamp;
   logic [CNT_W:0]      word_span;
   logic [FIDX_W-1:0]   req_frame;
   logic [WADDR_W-1:0]  frame_word;
   logic [LOG_WB-1:0]   frame_bit;
   logic [WB-1:0]       init_mask;
   logic [WB-1:0]       valid_mask;
   logic [WB-1:0]       free_bits;
   logic                hit;
   logic [LOG_WB-1:0]   hit_idx;
   logic [FULL_W-1:0]   hit_addr_full;
   logic                req_take;
   logic                out_free;

   bfa_ram #(
      .WIDTH (WB),
      .DEPTH (WORD_COUNT),
      .AW    (WADDR_W)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Effective total is clamped to what the bitmap holds.
   always_comb begin
      if (32'(total_ff) > 32'(MAX_FRAMES)) begin
         eff_tot = CNT_W'(MAX_FRAMES);
      end else begin
         eff_tot = total_ff;
      end
      resv_clamp = (reserved_ff < eff_tot) ? reserved_ff : eff_tot;
      // words that hold frames below the total
      word_span = ({1'b0, eff_tot} + (CNT_W + 1)'(WB - 1)) >> LOG_WB;
   end

   assign req_frame  = FIDX_W'(req_byte_addr >> OFF_W);
   assign frame_word = WADDR_W'(frame_ff >> LOG_WB);
   assign frame_bit  = frame_ff[LOG_WB-1:0];

   // Init pattern for the current sweep word: ones for frames still reserved.
   always_comb begin
      for (int i = 0; i < WB; i++) begin
         init_mask[i] = (32'(rem_ff) >= 32'(WB)) || (LOG_WB'(i) < rem_ff[LOG_WB-1:0]);
      end
   end

   // Only the last word of the scan can hold frames at or above the total.
   always_comb begin
      for (int i = 0; i < WB; i++) begin
         valid_mask[i] = (chk_word_ff != last_ff) || (eff_tot[LOG_WB-1:0] == '0) ||
                         (LOG_WB'(i) < eff_tot[LOG_WB-1:0]);
      end
      free_bits = ~ram_rd_data & valid_mask;
      hit       = |free_bits;
      hit_idx   = '0;
      for (int i = WB - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            hit_idx = LOG_WB'(i);
         end
      end
      hit_addr_full = FULL_W'({chk_word_ff, hit_idx}) << OFF_W;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign ram_rd_addr = (state_ff == S_SCAN) ? iss_ff : frame_word;

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      reserved_in   = reserved_ff;
      cnt_in        = cnt_ff;
      sweep_in      = sweep_ff;
      rem_in        = rem_ff;
      init_rsp_in   = init_rsp_ff;
      iss_in        = iss_ff;
      iss_done_in   = iss_done_ff;
      chk_vld_in    = 1'b0;
      chk_word_in   = chk_word_ff;
      last_in       = last_ff;
      frame_in      = frame_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = sweep_ff;
      ram_wr_data   = init_mask;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TOTAL:    total_in    = csr_wdata;
            CSR_RESERVED: reserved_in = csr_wdata;
            default:      ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               res_status_in = STAT_OK;
               res_addr_in   = '0;
               state_in      = S_RESP;
               case (req_action)
                  ACT_INIT: begin
                     sweep_in    = '0;
                     rem_in      = resv_clamp;
                     init_rsp_in = 1'b1;
                     cnt_in      = eff_tot - resv_clamp;
                     state_in    = S_CLEAR;
                  end
                  ACT_ALLOC: begin
                     if (cnt_ff == '0 || eff_tot == '0) begin
                        res_status_in = STAT_OOM;
                     end else begin
                        iss_in      = '0;
                        iss_done_in = 1'b0;
                        last_in     = WADDR_W'(word_span - 1'b1);
                        state_in    = S_SCAN;
                     end
                  end
                  ACT_FREE: begin
                     frame_in = req_frame;
                     if (32'(req_frame) >= 32'(eff_tot)) begin
                        res_status_in = STAT_RANGE;
                     end else begin
                        state_in = S_FRD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = init_mask;
            rem_in      = (32'(rem_ff) >= 32'(WB)) ? rem_ff - CNT_W'(WB) : '0;
            if (sweep_ff == WORD_LAST) begin
               state_in = init_rsp_ff ? S_RESP : S_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         S_SCAN: begin
            // issue side: one word read per cycle
            if (!iss_done_ff) begin
               chk_vld_in  = 1'b1;
               chk_word_in = iss_ff;
               iss_in      = iss_ff + 1'b1;
               iss_done_in = (iss_ff == last_ff);
            end
            // check side: data of the word issued last cycle
            if (chk_vld_ff) begin
               if (hit) begin
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = chk_word_ff;
                  ram_wr_data   = ram_rd_data | (WB'(1) << hit_idx);
                  cnt_in        = cnt_ff - 1'b1;
                  res_addr_in   = hit_addr_full[ADDR_W-1:0];
                  chk_vld_in    = 1'b0;
                  state_in      = S_RESP;
               end else if (chk_word_ff == last_ff) begin
                  res_status_in = STAT_OOM;
                  chk_vld_in    = 1'b0;
                  state_in      = S_RESP;
               end
            end
         end

         S_FRD: begin
            state_in = S_FCHK;
         end

         S_FCHK: begin
            if (ram_rd_data[frame_bit]) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = frame_word;
               ram_wr_data = ram_rd_data & ~(WB'(1) << frame_bit);
               if (cnt_ff != CNT_SAT) begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               res_status_in = STAT_NOTALLOC;
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_cnt_in    = cnt_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;     // clearing pass after reset
         total_ff     <= TOTAL_RST;
         reserved_ff  <= RESERVED_RST;
         cnt_ff       <= CNT_W'(MAX_FRAMES);
         sweep_ff     <= '0;
         rem_ff       <= '0;
         init_rsp_ff  <= 1'b0;
         iss_done_ff  <= 1'b0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         reserved_ff  <= reserved_in;
         cnt_ff       <= cnt_in;
         sweep_ff     <= sweep_in;
         rem_ff       <= rem_in;
         init_rsp_ff  <= init_rsp_in;
         iss_done_ff  <= iss_done_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff        <= iss_in;
      chk_word_ff   <= chk_word_in;
      last_ff       <= last_in;
      frame_ff      <= frame_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_alloc_addr = rsp_addr_ff;
   assign rsp_free_count = rsp_cnt_ff;

endmodule
